@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ hw/rtl/mdc_pkg.sv @@
// ----------------------------------------------------------------------------
// mdc_pkg
// Types, codes and helper functions of the depth-first maze carver.
// ----------------------------------------------------------------------------
package mdc_pkg;

  // Input operation codes; the spare code behaves as a read.
  typedef enum logic [1:0] {
    OP_CARVE    = 2'd0,
    OP_RESTART  = 2'd1,
    OP_READ     = 2'd2,
    OP_READ_ALT = 2'd3
  } opcode_e;

  // Result action codes.
  typedef enum logic [2:0] {
    ACT_CARVED    = 3'd0,
    ACT_BACKTRACK = 3'd1,
    ACT_COMPLETE  = 3'd2,
    ACT_CELL_READ = 3'd3,
    ACT_RESTARTED = 3'd4
  } action_e;

  // Carve directions.
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Cell word bits.
  localparam logic [4:0] BIT_VISITED = 5'b00001;
  localparam logic [4:0] BIT_N       = 5'b00010;
  localparam logic [4:0] BIT_E       = 5'b00100;
  localparam logic [4:0] BIT_S       = 5'b01000;
  localparam logic [4:0] BIT_W       = 5'b10000;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_N,
    S_RD_E,
    S_RD_S,
    S_RD_W,
    S_RD_TOP,
    S_PICK,
    S_WR_TOP,
    S_POP_WAIT,
    S_RD_WAIT
  } seq_state_e;

  // One result item.
  typedef struct packed {
    action_e    action;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
    logic [1:0] direction;
    logic [4:0] cell_bits;
    logic       done_res;
  } result_t;

  // Remainder of a 15-bit word by three, by folding base-4 digits.
  function automatic logic [1:0] mod3(input logic [14:0] v);
    logic [15:0] x;
    logic [4:0]  s1;
    logic [2:0]  s2;
    logic [2:0]  s3;
    x  = {1'b0, v};
    s1 = 5'(x[1:0]) + 5'(x[3:2]) + 5'(x[5:4]) + 5'(x[7:6])
       + 5'(x[9:8]) + 5'(x[11:10]) + 5'(x[13:12]) + 5'(x[15:14]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    if (s3 >= 3'd3) begin
      s3 = s3 - 3'd3;
    end
    return s3[1:0];
  endfunction

  // Path bit of a cell word for a direction.
  function automatic logic [4:0] path_bit(input logic [1:0] d);
    logic [4:0] b;
    unique case (d)
      DIR_N:   b = BIT_N;
      DIR_E:   b = BIT_E;
      DIR_S:   b = BIT_S;
      default: b = BIT_W;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/mdc_if.sv @@
// ----------------------------------------------------------------------------
// mdc_if
// Valid/ready channels of the maze carver: input items and result items.
// ----------------------------------------------------------------------------
interface mdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [14:0] random_word;
  logic [5:0]  read_col;
  logic [5:0]  read_row;

  modport source (output valid, opcode, random_word, read_col, read_row, input ready);
  modport sink   (input valid, opcode, random_word, read_col, read_row, output ready);
endinterface

interface mdc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [5:0] cell_col;
  logic [5:0] cell_row;
  logic [1:0] direction;
  logic [4:0] cell_bits;
  logic       done_res;

  modport source (output valid, action, cell_col, cell_row, direction, cell_bits, done_res,
                  input ready);
  modport sink   (input valid, action, cell_col, cell_row, direction, cell_bits, done_res,
                  output ready);
endinterface

@@ hw/rtl/mdc_ram.sv @@
// ----------------------------------------------------------------------------
// mdc_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mdc_ram #(
  parameter int unsigned DW = 5,
  parameter int unsigned AW = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  // Write, and registered read of the addressed entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mdc_seq.sv @@
// ----------------------------------------------------------------------------
// mdc_seq
// Step sequencer: reads neighbours from the cell store, picks a direction,
// writes both cells back and pushes or pops the path stack.
// ----------------------------------------------------------------------------
module mdc_seq #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned AW       = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mdc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mdc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  mdc_in_if.sink                           in_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output mdc_pkg::result_t                 res_o,
  output logic                             cell_we_o,
  output logic [AW-1:0]                    cell_addr_o,
  output logic [4:0]                       cell_wdata_o,
  input  logic [4:0]                       cell_rdata_i,
  output logic                             stk_we_o,
  output logic [AW-1:0]                    stk_addr_o,
  output logic [AW-1:0]                    stk_wdata_o,
  input  logic [AW-1:0]                    stk_rdata_i
);

  import mdc_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned RW    = AW - CW;
  localparam int unsigned CELLS = MAX_COLS * MAX_ROWS;
  localparam int unsigned CNT_W = $clog2(CELLS + 1);
  localparam int unsigned W_LIM = (MAX_COLS < 127) ? MAX_COLS : 127;
  localparam int unsigned H_LIM = (MAX_ROWS < 127) ? MAX_ROWS : 127;
  localparam logic [6:0]  W_RST = 7'((W_LIM < 64) ? W_LIM : 64);
  localparam logic [6:0]  H_RST = 7'((H_LIM < 64) ? H_LIM : 64);

  seq_state_e        state_q, state_d;
  logic [6:0]        eff_w_q, eff_w_d, eff_h_q, eff_h_d;
  logic [CW-1:0]     top_col_q, top_col_d, nxt_col_q, nxt_col_d;
  logic [RW-1:0]     top_row_q, top_row_d, nxt_row_q, nxt_row_d;
  logic [CNT_W-1:0]  depth_q, depth_d, visited_q, visited_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [4:0]        nbrw_q [4];
  logic [4:0]        nbrw_d [4];
  logic [4:0]        tw_q, tw_d;
  logic [14:0]       rnd_q, rnd_d;
  result_t           res_q, res_d;
  logic              pend_q, pend_d;

  logic [13:0]       area;
  logic              done_now;
  logic [3:0]        nv;
  logic [3:0]        avail;
  logic [2:0]        n_avail;
  logic [1:0]        pick_k;
  logic [1:0]        pick_dir;
  logic [CW-1:0]     cand_col [4];
  logic [RW-1:0]     cand_row [4];
  logic [CW-1:0]     rd_col;
  logic [RW-1:0]     rd_row;
  logic              rd_in_range;

  // Clamp a register value to one and to the limit.
  function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] lim);
    logic [6:0] r;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Narrow a coordinate to the six bits of a result field.
  function automatic logic [5:0] col6(input logic [CW-1:0] c);
    logic [8:0] t;
    t = 9'(c);
    return t[5:0];
  endfunction

  function automatic logic [5:0] row6(input logic [RW-1:0] r);
    logic [8:0] t;
    t = 9'(r);
    return t[5:0];
  endfunction

  // Completion status from the counters.
  assign area     = 14'(eff_w_q) * 14'(eff_h_q);
  assign done_now = (17'(visited_q) >= 17'(area)) || (depth_q == '0);

  // Neighbour coordinates and whether they lie in the area in use.
  always_comb begin
    cand_col[0] = top_col_q;
    cand_row[0] = top_row_q - RW'(1);
    cand_col[1] = top_col_q + CW'(1);
    cand_row[1] = top_row_q;
    cand_col[2] = top_col_q;
    cand_row[2] = top_row_q + RW'(1);
    cand_col[3] = top_col_q - CW'(1);
    cand_row[3] = top_row_q;
    nv[0] = (top_row_q != '0);
    nv[1] = (9'(top_col_q) + 9'd1) < 9'(eff_w_q);
    nv[2] = (9'(top_row_q) + 9'd1) < 9'(eff_h_q);
    nv[3] = (top_col_q != '0);
  end

  // Direction choice among the unvisited neighbours, north first.
  always_comb begin
    logic [1:0] cnt;
    logic       found;
    cnt      = 2'd0;
    found    = 1'b0;
    pick_dir = DIR_N;
    for (int d = 0; d < 4; d++) begin
      avail[d] = nv[d] & ~nbrw_q[d][0];
    end
    n_avail = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);
    case (n_avail)
      3'd1:    pick_k = 2'd0;
      3'd2:    pick_k = {1'b0, rnd_q[0]};
      3'd3:    pick_k = mod3(rnd_q);
      default: pick_k = rnd_q[1:0];
    endcase
    for (int d = 0; d < 4; d++) begin
      if (avail[d] && !found) begin
        if (cnt == pick_k) begin
          pick_dir = 2'(d);
          found    = 1'b1;
        end
        cnt = cnt + 2'd1;
      end
    end
  end

  // Read request coordinates, in store layout.
  always_comb begin
    logic [8:0] c9, r9;
    c9          = 9'(in_i.read_col);
    r9          = 9'(in_i.read_row);
    rd_col      = c9[CW-1:0];
    rd_row      = r9[RW-1:0];
    rd_in_range = (7'(in_i.read_col) < eff_w_q) && (7'(in_i.read_row) < eff_h_q);
  end

  assign in_i.ready  = (state_q == S_IDLE) && !pend_q;
  assign res_valid_o = pend_q;
  assign res_o       = res_q;

  // Next state, memory requests and counter updates.
  always_comb begin
    state_d      = state_q;
    eff_w_d      = eff_w_q;
    eff_h_d      = eff_h_q;
    top_col_d    = top_col_q;
    top_row_d    = top_row_q;
    nxt_col_d    = nxt_col_q;
    nxt_row_d    = nxt_row_q;
    depth_d      = depth_q;
    visited_d    = visited_q;
    clr_d        = clr_q;
    nbrw_d       = nbrw_q;
    tw_d         = tw_q;
    rnd_d        = rnd_q;
    res_d        = res_q;
    pend_d       = pend_q & ~res_ready_i;
    cell_we_o    = 1'b0;
    cell_addr_o  = {top_row_q, top_col_q};
    cell_wdata_o = tw_q;
    stk_we_o     = 1'b0;
    stk_addr_o   = depth_q[AW-1:0];
    stk_wdata_o  = {nxt_row_q, nxt_col_q};

    unique case (state_q)
      // Sweep the cell store; the origin comes back visited.
      S_CLEAR: begin
        cell_we_o    = 1'b1;
        cell_addr_o  = clr_q;
        cell_wdata_o = (clr_q == '0) ? BIT_VISITED : 5'd0;
        stk_we_o     = (clr_q == '0);
        stk_addr_o   = '0;
        stk_wdata_o  = '0;
        clr_d        = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          res_d.direction = DIR_N;
          unique case (opcode_e'(in_i.opcode)) inside
            OP_RESTART: begin
              res_d.action    = ACT_RESTARTED;
              res_d.cell_col  = 6'd0;
              res_d.cell_row  = 6'd0;
              res_d.cell_bits = BIT_VISITED;
              res_d.done_res  = (area == 14'd1);
              pend_d          = 1'b1;
              top_col_d       = '0;
              top_row_d       = '0;
              depth_d         = CNT_W'(1);
              visited_d       = CNT_W'(1);
              clr_d           = '0;
              state_d         = S_CLEAR;
            end
            OP_READ, OP_READ_ALT: begin
              res_d.action    = ACT_CELL_READ;
              res_d.cell_col  = in_i.read_col;
              res_d.cell_row  = in_i.read_row;
              res_d.cell_bits = 5'd0;
              res_d.done_res  = done_now;
              cell_addr_o     = {rd_row, rd_col};
              if (rd_in_range) begin
                state_d = S_RD_WAIT;
              end else begin
                pend_d = 1'b1;
              end
            end
            default: begin
              if (done_now) begin
                res_d.action    = ACT_COMPLETE;
                res_d.cell_col  = (depth_q != '0) ? col6(top_col_q) : 6'd0;
                res_d.cell_row  = (depth_q != '0) ? row6(top_row_q) : 6'd0;
                res_d.cell_bits = 5'd0;
                res_d.done_res  = 1'b1;
                pend_d          = 1'b1;
              end else begin
                rnd_d   = in_i.random_word;
                state_d = S_RD_N;
              end
            end
          endcase
        end
      end

      // Neighbour reads, each word captured in the cycle after its address.
      S_RD_N: begin
        cell_addr_o = {cand_row[0], cand_col[0]};
        state_d     = S_RD_E;
      end
      S_RD_E: begin
        cell_addr_o = {cand_row[1], cand_col[1]};
        nbrw_d[0]   = cell_rdata_i;
        state_d     = S_RD_S;
      end
      S_RD_S: begin
        cell_addr_o = {cand_row[2], cand_col[2]};
        nbrw_d[1]   = cell_rdata_i;
        state_d     = S_RD_W;
      end
      S_RD_W: begin
        cell_addr_o = {cand_row[3], cand_col[3]};
        nbrw_d[2]   = cell_rdata_i;
        state_d     = S_RD_TOP;
      end
      S_RD_TOP: begin
        cell_addr_o = {top_row_q, top_col_q};
        nbrw_d[3]   = cell_rdata_i;
        state_d     = S_PICK;
      end

      // Carve into the chosen neighbour, or pop when none is left.
      S_PICK: begin
        res_d.cell_col = col6(top_col_q);
        res_d.cell_row = row6(top_row_q);
        if (n_avail != 3'd0) begin
          res_d.action    = ACT_CARVED;
          res_d.direction = pick_dir;
          res_d.cell_bits = cell_rdata_i | path_bit(pick_dir);
          tw_d            = cell_rdata_i | path_bit(pick_dir);
          nxt_col_d       = cand_col[pick_dir];
          nxt_row_d       = cand_row[pick_dir];
          cell_we_o       = 1'b1;
          cell_addr_o     = {cand_row[pick_dir], cand_col[pick_dir]};
          cell_wdata_o    = nbrw_q[pick_dir] | BIT_VISITED | path_bit(pick_dir ^ 2'd2);
          if (32'(depth_q) < CELLS) begin
            stk_we_o    = 1'b1;
            stk_addr_o  = depth_q[AW-1:0];
            stk_wdata_o = {cand_row[pick_dir], cand_col[pick_dir]};
            depth_d     = depth_q + CNT_W'(1);
          end
          visited_d = visited_q + CNT_W'(1);
          state_d   = S_WR_TOP;
        end else begin
          res_d.action    = ACT_BACKTRACK;
          res_d.direction = DIR_N;
          res_d.cell_bits = cell_rdata_i;
          res_d.done_res  = (17'(visited_q) >= 17'(area)) || (depth_q == CNT_W'(1));
          depth_d         = depth_q - CNT_W'(1);
          if (depth_q > CNT_W'(1)) begin
            stk_addr_o = depth_q[AW-1:0] - AW'(2);
            state_d    = S_POP_WAIT;
          end else begin
            pend_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end

      // Write back the old top and move onto the new cell.
      S_WR_TOP: begin
        cell_we_o      = 1'b1;
        cell_addr_o    = {top_row_q, top_col_q};
        cell_wdata_o   = tw_q;
        top_col_d      = nxt_col_q;
        top_row_d      = nxt_row_q;
        res_d.done_res = done_now;
        pend_d         = 1'b1;
        state_d        = S_IDLE;
      end

      // New stack top arrives from the path stack.
      S_POP_WAIT: begin
        top_col_d = stk_rdata_i[CW-1:0];
        top_row_d = stk_rdata_i[AW-1:CW];
        pend_d    = 1'b1;
        state_d   = S_IDLE;
      end

      S_RD_WAIT: begin
        res_d.cell_bits = cell_rdata_i;
        pend_d          = 1'b1;
        state_d         = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    // A write to the width or height register restarts generation.
    if (cfg_we_i && (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT)) begin
      if (cfg_idx_i == CFG_WIDTH) begin
        eff_w_d = clamp7(cfg_wdata_i, 7'(W_LIM));
      end else begin
        eff_h_d = clamp7(cfg_wdata_i, 7'(H_LIM));
      end
      top_col_d = '0;
      top_row_d = '0;
      depth_d   = CNT_W'(1);
      visited_d = CNT_W'(1);
      clr_d     = '0;
      state_d   = S_CLEAR;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      eff_w_q   <= W_RST;
      eff_h_q   <= H_RST;
      top_col_q <= '0;
      top_row_q <= '0;
      depth_q   <= CNT_W'(1);
      visited_q <= CNT_W'(1);
      clr_q     <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      eff_w_q   <= eff_w_d;
      eff_h_q   <= eff_h_d;
      top_col_q <= top_col_d;
      top_row_q <= top_row_d;
      depth_q   <= depth_d;
      visited_q <= visited_d;
      clr_q     <= clr_d;
      pend_q    <= pend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    nxt_col_q <= nxt_col_d;
    nxt_row_q <= nxt_row_d;
    nbrw_q    <= nbrw_d;
    tw_q      <= tw_d;
    rnd_q     <= rnd_d;
    res_q     <= res_d;
  end

endmodule

@@ hw/rtl/dfs_maze_carver_top.sv @@
// ----------------------------------------------------------------------------
// dfs_maze_carver_top
// Randomised depth-first maze generator with a cell store and a path stack.
// ----------------------------------------------------------------------------
// One item is in work at a time. A carve step runs through five reads of
// the single-port cell store (four neighbours and the stack top), a step
// that chooses and writes the new cell, a step that writes back the old top
// or fetches the popped top from the path stack, and the load of the output
// register; a backtrack that empties the stack needs no fetch. A read inside
// the area in use waits for the cell store; a read outside it, a completed
// step or a restart is answered from the idle state. After reset, a restart
// item or a write to the width or height register, the cell store is cleared
// one entry a cycle, all 2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) entries (4096
// at the defaults), during which no item is taken; the restart result is
// offered at once. A finished result waits in an output register, so the
// next item may be taken while it is still pending.
module dfs_maze_carver_top #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mdc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mdc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  mdc_in_if.sink                         in_i,
  mdc_out_if.source                      out_o
);

  import mdc_pkg::*;

`include "assert_macros.svh"

  localparam int unsigned AW = $clog2(MAX_COLS) + $clog2(MAX_ROWS);

  logic          res_valid, res_take;
  result_t       res, out_q;
  logic          out_valid_q;
  logic          cell_we, stk_we;
  logic [AW-1:0] cell_addr, stk_addr, stk_wdata, stk_rdata;
  logic [4:0]    cell_wdata, cell_rdata;

  mdc_seq #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .AW       (AW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_i         (in_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_take),
    .res_o        (res),
    .cell_we_o    (cell_we),
    .cell_addr_o  (cell_addr),
    .cell_wdata_o (cell_wdata),
    .cell_rdata_i (cell_rdata),
    .stk_we_o     (stk_we),
    .stk_addr_o   (stk_addr),
    .stk_wdata_o  (stk_wdata),
    .stk_rdata_i  (stk_rdata)
  );

  // Cell store: one word of visited and path bits per cell.
  mdc_ram #(
    .DW (5),
    .AW (AW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .addr_i  (cell_addr),
    .wdata_i (cell_wdata),
    .rdata_o (cell_rdata)
  );

  // Path stack of cell coordinates.
  mdc_ram #(
    .DW (AW),
    .AW (AW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .addr_i  (stk_addr),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_take = res_valid && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.action    = out_q.action;
  assign out_o.cell_col  = out_q.cell_col;
  assign out_o.cell_row  = out_q.cell_row;
  assign out_o.direction = out_q.direction;
  assign out_o.cell_bits = out_q.cell_bits;
  assign out_o.done_res  = out_q.done_res;

  // A write to the width register starts the clearing sweep, which blocks input.
  `ASSERT_NEXT(a_cfg_blocks_input, clk_i, rst_ni, cfg_we_i && cfg_idx_i == CFG_WIDTH, !in_i.ready)
  // Only one item is in work at a time.
  `ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  // A result handed over always lands in the output register.
  `ASSERT_NEXT(a_res_lands, clk_i, rst_ni, res_take, out_o.valid)

endmodule
